// File: hdl/tcdr_pkg.sv
// ----------------------------------------------------------------------------
// tcdr_pkg
// Shared types, codes and constants of the two-channel dimming ramp.
// ----------------------------------------------------------------------------
package tcdr_pkg;

    localparam int unsigned NUM_CH     = 2;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned BASE_W     = 3;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned NUM_DIV    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE_CH0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE_CH1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RELOAD_CH0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RELOAD_CH1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL_CH0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL_CH1   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_MODE       = 3'd6;

    localparam logic [BASE_W-1:0] BASE_OFF   = 3'd0;
    localparam logic [BASE_W-1:0] BASE_EVERY = 3'd1;
    localparam logic [BASE_W-1:0] BASE_DIV0  = 3'd2;
    localparam logic [BASE_W-1:0] BASE_DIV1  = 3'd3;
    localparam logic [BASE_W-1:0] BASE_DIV2  = 3'd4;
    localparam logic [BASE_W-1:0] BASE_DIV3  = 3'd5;

    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = 8'd15;

    // lowest-set-bit positions for the divided timebases
    localparam logic [TICK_W-1:0] DIV_MASK [NUM_DIV] = '{
        16'h0008, 16'h0080, 16'h0800, 16'h8000
    };

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [LEVEL_W-1:0] reload;
        logic [LEVEL_W-1:0] min_level;
        logic               jump;
    } t_chan_cfg;

    typedef struct packed {
        logic               en;
        logic               op;
        logic               sel;
        logic [LEVEL_W-1:0] value;
        logic [NUM_DIV-1:0] div_hit;
    } t_chan_ctl;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm;
        logic               on;
    } t_chan_res;

endpackage

// File: hdl/two_channel_dimming_ramp_core.sv
// ----------------------------------------------------------------------------
// two_channel_dimming_ramp_core
// Two-channel dimmer ramp with configurable timebase, step period and floor.
// ----------------------------------------------------------------------------
// One request per clock is taken unless the output side stalls. A request
// lands in an input register, the whole two-channel update is one pass of
// logic from there into the result register, so each request gives exactly
// one result. A stalled result holds in the result register while one
// further request waits in the input register.
// Configuration is written through its own channel, always ready, and should
// only be written with no request in flight.
// ----------------------------------------------------------------------------
module two_channel_dimming_ramp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcdr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcdr_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic                                i_channel,
    input  logic [tcdr_pkg::LEVEL_W-1:0]        i_value,

    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tcdr_pkg::LEVEL_W-1:0]        o_pwm_ch0,
    output logic [tcdr_pkg::LEVEL_W-1:0]        o_pwm_ch1,
    output logic                                o_on_ch0,
    output logic                                o_on_ch1
);

    tcdr_pkg::t_chan_cfg r_cfg [tcdr_pkg::NUM_CH];

    logic                         r_in_valid;
    logic                         r_op;
    logic                         r_channel;
    logic [tcdr_pkg::LEVEL_W-1:0] r_value;

    logic                         r_out_valid;
    logic [tcdr_pkg::LEVEL_W-1:0] r_pwm_ch0;
    logic [tcdr_pkg::LEVEL_W-1:0] r_pwm_ch1;
    logic                         r_on_ch0;
    logic                         r_on_ch1;

    logic                         w_move;
    logic                         w_take;
    logic [tcdr_pkg::NUM_DIV-1:0] w_div_hit;

    tcdr_pkg::t_chan_ctl w_ctl [tcdr_pkg::NUM_CH];
    tcdr_pkg::t_chan_res w_res [tcdr_pkg::NUM_CH];

    assign w_move      = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || w_move;
    assign w_take      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tcdr_pkg::NUM_CH; c++) begin
                r_cfg[c].base      <= tcdr_pkg::BASE_OFF;
                r_cfg[c].reload    <= '0;
                r_cfg[c].min_level <= tcdr_pkg::MIN_LEVEL_RESET;
                r_cfg[c].jump      <= 1'b0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcdr_pkg::REG_STEP_BASE_CH0:   r_cfg[0].base <= i_cfg_data[tcdr_pkg::BASE_W-1:0];
                tcdr_pkg::REG_STEP_BASE_CH1:   r_cfg[1].base <= i_cfg_data[tcdr_pkg::BASE_W-1:0];
                tcdr_pkg::REG_STEP_RELOAD_CH0: r_cfg[0].reload <= i_cfg_data;
                tcdr_pkg::REG_STEP_RELOAD_CH1: r_cfg[1].reload <= i_cfg_data;
                tcdr_pkg::REG_MIN_LEVEL_CH0:   r_cfg[0].min_level <= i_cfg_data;
                tcdr_pkg::REG_MIN_LEVEL_CH1:   r_cfg[1].min_level <= i_cfg_data;
                tcdr_pkg::REG_JUMP_MODE: begin
                    r_cfg[0].jump <= i_cfg_data[0];
                    r_cfg[1].jump <= i_cfg_data[1];
                end
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op      <= i_op;
            r_channel <= i_channel;
            r_value   <= i_value;
        end
    end

    tcdr_tick u_tick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_move && (r_op == tcdr_pkg::OP_TICK)),
        .o_div_hit (w_div_hit)
    );

    for (genvar g = 0; g < tcdr_pkg::NUM_CH; g++) begin : g_chan
        assign w_ctl[g].en      = w_move;
        assign w_ctl[g].op      = r_op;
        assign w_ctl[g].sel     = (r_channel == 1'(g));
        assign w_ctl[g].value   = r_value;
        assign w_ctl[g].div_hit = w_div_hit;

        tcdr_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg[g]),
            .i_ctl   (w_ctl[g]),
            .o_res   (w_res[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_pwm_ch0 <= w_res[0].pwm;
            r_pwm_ch1 <= w_res[1].pwm;
            r_on_ch0  <= w_res[0].on;
            r_on_ch1  <= w_res[1].on;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pwm_ch0 = r_pwm_ch0;
    assign o_pwm_ch1 = r_pwm_ch1;
    assign o_on_ch0  = r_on_ch0;
    assign o_on_ch1  = r_on_ch1;

    // a taken request is held until it has passed into the result register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_in_valid)
        else $error("taken request not held in input register");

    // a request in flight reaches the result register
    a_move_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("moved request gave no result");

    // a stalled result blocks the pass while a request waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_move)
        else $error("pending result overwritten");

    // a nonzero drive level is never below the channel's minimum floor
    a_pwm_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> ((r_pwm_ch0 == '0) || (r_pwm_ch0 >= $past(r_cfg[0].min_level)))
                && ((r_pwm_ch1 == '0) || (r_pwm_ch1 >= $past(r_cfg[1].min_level))))
        else $error("drive level below minimum floor");

endmodule

// File: hdl/tcdr_tick.sv
// ----------------------------------------------------------------------------
// tcdr_tick
// Tick counter, advanced on each tick request, and divided-timebase strobes for the next tick.
// ----------------------------------------------------------------------------
module tcdr_tick (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_advance,
    output logic [tcdr_pkg::NUM_DIV-1:0]       o_div_hit
);

    logic [tcdr_pkg::TICK_W-1:0] r_tick_count;
    logic [tcdr_pkg::TICK_W-1:0] n_tick_count;
    logic [tcdr_pkg::TICK_W-1:0] w_lowbit;

    assign n_tick_count = r_tick_count + tcdr_pkg::TICK_W'(1);
    assign w_lowbit     = n_tick_count & (~n_tick_count + tcdr_pkg::TICK_W'(1));

    always_comb begin
        for (int k = 0; k < tcdr_pkg::NUM_DIV; k++) begin
            o_div_hit[k] = |(w_lowbit & tcdr_pkg::DIV_MASK[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
        end else if (i_advance) begin
            r_tick_count <= n_tick_count;
        end
    end

endmodule

// File: hdl/tcdr_chan.sv
// ----------------------------------------------------------------------------
// tcdr_chan
// One dimmer channel: target, step timer, level ramp and soft-off state.
// ----------------------------------------------------------------------------
module tcdr_chan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcdr_pkg::t_chan_cfg  i_cfg,
    input  tcdr_pkg::t_chan_ctl  i_ctl,
    output tcdr_pkg::t_chan_res  o_res
);

    logic [tcdr_pkg::LEVEL_W-1:0] r_step_count, n_step_count;
    logic [tcdr_pkg::LEVEL_W-1:0] r_level,      n_level;
    logic [tcdr_pkg::LEVEL_W-1:0] r_target,     n_target;
    logic                         r_off_pend,   n_off_pend;
    logic                         r_on,         n_on;

    logic                         w_dec;
    logic [tcdr_pkg::LEVEL_W-1:0] w_sc;
    logic [tcdr_pkg::LEVEL_W-1:0] w_lv;

    always_comb begin
        case (i_cfg.base)
            tcdr_pkg::BASE_EVERY: w_dec = 1'b1;
            tcdr_pkg::BASE_DIV0:  w_dec = i_ctl.div_hit[0];
            tcdr_pkg::BASE_DIV1:  w_dec = i_ctl.div_hit[1];
            tcdr_pkg::BASE_DIV2:  w_dec = i_ctl.div_hit[2];
            tcdr_pkg::BASE_DIV3:  w_dec = i_ctl.div_hit[3];
            default:              w_dec = 1'b0;
        endcase
    end

    always_comb begin
        n_step_count = r_step_count;
        n_level      = r_level;
        n_target     = r_target;
        n_off_pend   = r_off_pend;
        n_on         = r_on;
        w_sc         = r_step_count;
        w_lv         = r_level;

        if (i_ctl.op == tcdr_pkg::OP_SET) begin
            if (i_ctl.sel) begin
                if (i_ctl.value != '0) begin
                    n_on     = 1'b1;
                    n_target = (i_ctl.value >= i_cfg.min_level) ? i_ctl.value
                                                                : i_cfg.min_level;
                end else begin
                    n_target   = '0;
                    n_off_pend = 1'b1;
                end
                if (i_cfg.jump) begin
                    n_level = n_target;
                end
            end
        end else begin
            if (w_dec && (r_step_count != '0)) begin
                w_sc = r_step_count - tcdr_pkg::LEVEL_W'(1);
            end
            n_step_count = w_sc;
            if ((i_cfg.base != tcdr_pkg::BASE_OFF) && (w_sc == '0)) begin
                n_step_count = i_cfg.reload;
                if (r_target > r_level) begin
                    w_lv = r_level + tcdr_pkg::LEVEL_W'(1);
                    if (w_lv < i_cfg.min_level) begin
                        w_lv = i_cfg.min_level;
                    end
                end
                if (r_target < w_lv) begin
                    w_lv = w_lv - tcdr_pkg::LEVEL_W'(1);
                    if (w_lv < i_cfg.min_level) begin
                        w_lv = '0;
                    end
                end
            end
            n_level = w_lv;
            if (r_off_pend && (w_lv == '0)) begin
                n_off_pend = 1'b0;
                n_on       = 1'b0;
            end
        end
    end

    // drive level of the updated state, floored at the minimum when nonzero
    assign o_res.pwm = ((n_level != '0) && (n_level < i_cfg.min_level)) ? i_cfg.min_level
                                                                        : n_level;
    assign o_res.on  = n_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= '0;
            r_level      <= '0;
            r_target     <= '0;
            r_off_pend   <= 1'b0;
            r_on         <= 1'b0;
        end else if (i_ctl.en) begin
            r_step_count <= n_step_count;
            r_level      <= n_level;
            r_target     <= n_target;
            r_off_pend   <= n_off_pend;
            r_on         <= n_on;
        end
    end

endmodule
